// ===== rtl/ffba_pkg.sv =====
// Shared constants and types for the first-fit block allocator.
// No dependencies; compiled before every other file.
`default_nettype none
package ffba_pkg;

	localparam int MAP_UNITS    = 1024;
	localparam int RESERVED_TOP = 64;
	localparam int SEARCH_UNITS = (MAP_UNITS > RESERVED_TOP) ? MAP_UNITS - RESERVED_TOP : 0;

	// Field widths of the request and response
	localparam int OP_W   = 2;
	localparam int SIZE_W = 11;
	localparam int UNIT_W = 10;

	// Map storage geometry
	localparam int WORD_W       = 32;
	localparam int BIT_SEL_W    = $clog2(WORD_W);
	localparam int MAP_WORDS    = MAP_UNITS / WORD_W;
	localparam int WORD_SEL_W   = $clog2(MAP_WORDS);
	localparam int SEARCH_WORDS = (SEARCH_UNITS + WORD_W - 1) / WORD_W;
	localparam int SLICE_W      = 8;
	localparam int SLICES       = WORD_W / SLICE_W;
	localparam int SLICE_SEL_W  = $clog2(SLICES);
	localparam int SLICE_BIT_W  = $clog2(SLICE_W);

	typedef enum logic [OP_W-1:0] {
		OP_CHECK = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_SLICE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/ffba_req_if.sv =====
// Request channel of the allocator: valid/ready plus request fields.
// Depends on ffba_pkg.
`default_nettype none
interface ffba_req_if;
	logic                        valid;
	logic                        ready;
	logic [ffba_pkg::OP_W-1:0]   operation;
	logic [ffba_pkg::SIZE_W-1:0] block_size;
	logic [ffba_pkg::UNIT_W-1:0] free_start;

	modport source (output valid, operation, block_size, free_start, input ready);
	modport sink   (input valid, operation, block_size, free_start, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffba_rsp_if.sv =====
// Response channel of the allocator: valid/ready plus result fields.
// Depends on ffba_pkg.
`default_nettype none
interface ffba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        granted;
	logic [ffba_pkg::UNIT_W-1:0] grant_address;

	modport source (output valid, granted, grant_address, input ready);
	modport sink   (input valid, granted, grant_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit contiguous allocator over a 1024-unit usage bitmap; top level.
// Depends on ffba_pkg, ffba_req_if and ffba_rsp_if.
//
// One request at a time; each transfer on req yields exactly one transfer on rsp.
// The map is a 32 x 32-bit memory with one read and one write port, plus a
// valid bit per word so reset and clear take effect at once (no clearing pass).
// Check and allocate scan the lowest 960 units word by word: each word is read,
// then scanned one 8-unit slice per cycle through a shared run counter, over
// the 30 searchable words. Allocate then marks the run, and free clears its
// range, with a read-modify-write (a read state, then a write state) per word
// touched. Clear, rejected check or allocate sizes (zero, or above 960) and a
// free of size zero go straight to done. A finished result sits in an output
// register; the next request is taken once the sequencer is back in idle.
`default_nettype none
module first_fit_block_allocator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);
	import ffba_pkg::*;

	state_t state_q, state_n;

	op_t                  op_q;
	logic [SIZE_W-1:0]    len_q;
	logic [UNIT_W-1:0]    lo_q, hi_q;
	logic [WORD_SEL_W-1:0] word_q;
	logic [SLICE_SEL_W-1:0] slice_q;
	logic [SIZE_W-1:0]    run_q;
	logic [UNIT_W-1:0]    first_q;
	logic                 res_granted_q;
	logic [UNIT_W-1:0]    res_addr_q;

	logic                 out_valid_q;
	logic                 out_granted_q;
	logic [UNIT_W-1:0]    out_addr_q;

	// Map storage
	logic [WORD_W-1:0]    mem_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_valid_q;
	logic [WORD_W-1:0]    rd_data_q;
	logic                 rd_valid_q;

	// Control strobes
	logic size_bad;
	logic mem_we;
	logic out_load;
	logic clear_map;

	// Scan slice results
	logic [WORD_W-1:0]  word_eff;
	logic [SLICE_W-1:0] slice_bits;
	logic [SIZE_W-1:0]  run_n;
	logic [UNIT_W-1:0]  first_n;
	logic               hit_n;

	// Mark datapath
	logic [WORD_W-1:0]  mark_mask;
	logic [WORD_W-1:0]  mark_word;
	logic [UNIT_W-1:0]  alloc_hi;
	logic [UNIT_W+1:0]  free_end;
	logic [UNIT_W-1:0]  free_hi;

	assign size_bad = (req.block_size == '0)
		|| ({21'd0, req.block_size} > 32'(SEARCH_UNITS));

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					unique case (op_t'(req.operation))
						OP_CHECK, OP_ALLOC: state_n = size_bad ? ST_DONE : ST_SCAN_RD;
						OP_FREE:  state_n = (req.block_size == '0) ? ST_DONE : ST_MARK_RD;
						OP_CLEAR: state_n = ST_DONE;
					endcase
				end
			end
			ST_SCAN_RD: state_n = ST_SCAN_SLICE;
			ST_SCAN_SLICE: begin
				if (hit_n) begin
					state_n = (op_q == OP_CHECK) ? ST_DONE : ST_MARK_RD;
				end else if (slice_q == SLICE_SEL_W'(SLICES - 1)) begin
					state_n = (word_q == WORD_SEL_W'(SEARCH_WORDS - 1)) ? ST_DONE : ST_SCAN_RD;
				end
			end
			ST_MARK_RD: state_n = ST_MARK_WR;
			ST_MARK_WR: begin
				if (word_q == hi_q[UNIT_W-1 -: WORD_SEL_W]) begin
					state_n = ST_DONE;
				end else begin
					state_n = ST_MARK_RD;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		clear_map = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				clear_map = req.valid && (op_t'(req.operation) == OP_CLEAR);
			end
			ST_MARK_WR: mem_we   = 1'b1;
			ST_DONE:    out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// One slice of the first-fit scan: up to eight dependent run updates
	assign word_eff   = rd_valid_q ? rd_data_q : '0;
	assign slice_bits = word_eff[slice_q*SLICE_W +: SLICE_W];

	always_comb begin
		logic [UNIT_W-1:0] idx;
		logic              used;
		run_n   = run_q;
		first_n = first_q;
		hit_n   = 1'b0;
		for (int j = 0; j < SLICE_W; j++) begin
			idx  = {word_q, slice_q, SLICE_BIT_W'(j)};
			used = slice_bits[j] || ({22'd0, idx} >= 32'(SEARCH_UNITS));
			if (!hit_n) begin
				if (used) begin
					run_n = '0;
				end else begin
					if (run_n == '0) begin
						first_n = idx;
					end
					run_n = run_n + SIZE_W'(1);
					if (run_n == len_q) begin
						hit_n = 1'b1;
					end
				end
			end
		end
	end

	// Mark and free range math
	assign alloc_hi = UNIT_W'({1'b0, first_n} + len_q - SIZE_W'(1));
	assign free_end = {2'b00, req.free_start} + {1'b0, req.block_size} - (UNIT_W+2)'(1);
	assign free_hi  = (free_end >= (UNIT_W+2)'(MAP_UNITS)) ? UNIT_W'(MAP_UNITS - 1)
		: free_end[UNIT_W-1:0];

	always_comb begin
		logic [UNIT_W-1:0] idx;
		for (int j = 0; j < WORD_W; j++) begin
			idx          = {word_q, BIT_SEL_W'(j)};
			mark_mask[j] = (idx >= lo_q) && (idx <= hi_q);
		end
	end

	assign mark_word = (op_q == OP_ALLOC) ? (word_eff | mark_mask) : (word_eff & ~mark_mask);

	// Map memory: one registered read, one write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[word_q] <= mark_word;
		end
		rd_data_q <= mem_q[word_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= row_valid_q[word_q];
			if (clear_map) begin
				row_valid_q <= '0;
			end else if (mem_we) begin
				row_valid_q[word_q] <= 1'b1;
			end
		end
	end

	// Sequencer state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q          <= op_t'(req.operation);
				len_q         <= req.block_size;
				run_q         <= '0;
				first_q       <= '0;
				slice_q       <= '0;
				res_granted_q <= 1'b0;
				res_addr_q    <= '0;
				lo_q          <= req.free_start;
				hi_q          <= free_hi;
				word_q        <= (op_t'(req.operation) == OP_FREE)
					? req.free_start[UNIT_W-1 -: WORD_SEL_W] : '0;
			end
			ST_SCAN_SLICE: begin
				run_q   <= run_n;
				first_q <= first_n;
				slice_q <= slice_q + SLICE_SEL_W'(1);
				if (hit_n) begin
					res_granted_q <= 1'b1;
					if (op_q == OP_ALLOC) begin
						res_addr_q <= first_n;
						lo_q       <= first_n;
						hi_q       <= alloc_hi;
						word_q     <= first_n[UNIT_W-1 -: WORD_SEL_W];
					end
				end else if (slice_q == SLICE_SEL_W'(SLICES - 1)) begin
					word_q <= word_q + WORD_SEL_W'(1);
				end
			end
			ST_MARK_WR: word_q <= word_q + WORD_SEL_W'(1);
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_granted_q <= res_granted_q;
			out_addr_q    <= res_addr_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted       = out_granted_q;
	assign rsp.grant_address = out_addr_q;

endmodule
`default_nettype wire
